FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/cprf_pkg.sv
// ----------------------------------------------------------------------------
// cprf_pkg
// Types, constants and the allowed-length table of the PRB run finder.
// ----------------------------------------------------------------------------
`default_nettype none

package cprf_pkg;

  localparam int unsigned PRB_W      = 7;
  localparam int unsigned MAX_PRB_DF = 100;
  localparam int unsigned MAP_W      = 100;
  localparam int unsigned LOW_W      = 64;
  localparam int unsigned HIGH_W     = 36;
  localparam int unsigned CELL_RESET = 100;
  // A run that breaks below this PRB index is dropped and the search goes on.
  localparam int unsigned EDGE_GUARD = 3;

  typedef struct packed {
    logic [LOW_W-1:0]  used_low;
    logic [HIGH_W-1:0] used_high;
    logic [PRB_W-1:0]  requested_len;
  } item_t;

  typedef struct packed {
    logic [PRB_W-1:0] run_start;
    logic [PRB_W-1:0] run_len;
    logic             exact_fit;
  } result_t;

  // Lengths of the form 2^a * 3^b * 5^c.
  function automatic logic len_allowed(input logic [PRB_W-1:0] v);
    logic ok;
    begin
      case (v)
        7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8, 7'd9, 7'd10, 7'd12,
        7'd15, 7'd16, 7'd18, 7'd20, 7'd24, 7'd25, 7'd27, 7'd30, 7'd32,
        7'd36, 7'd40, 7'd45, 7'd48, 7'd50, 7'd54, 7'd60, 7'd64, 7'd72,
        7'd75, 7'd80, 7'd81, 7'd90, 7'd96, 7'd100, 7'd108, 7'd120,
        7'd125: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      return ok;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/contiguous_prb_run_finder.sv
// ----------------------------------------------------------------------------
// contiguous_prb_run_finder
// Finds the first contiguous run of free PRBs that is not cut short below
// the edge guard, and trims its length to an allowed SC-FDMA size.
// ----------------------------------------------------------------------------
// A search starts on a cycle where start is high and busy is low. The bitmap
// is walked one PRB per cycle by a single compare-and-count step, over up to
// min(cell_prbs, MAX_PRB) PRBs, until the scan ends. The run length is then
// stepped down one per cycle until it hits an allowed size (at most 8 steps,
// from 89 down to 81), and the result is registered. The result is on result
// in the single cycle in which done is high and stays there until the next
// result; it cannot be held off. busy drops in that same cycle so a new
// search may start right away. cell_prbs is written through the cfg channel
// only while busy is low.
`default_nettype none

module contiguous_prb_run_finder #(
  parameter int unsigned MAX_PRB = cprf_pkg::MAX_PRB_DF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire cprf_pkg::item_t         item,
  output logic                         busy,
  output logic                         done,
  output cprf_pkg::result_t            result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [cprf_pkg::PRB_W-1:0] cfg_data
);
  import cprf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_REDUCE = 3'b100
  } state_t;

  localparam logic [PRB_W-1:0] MAX_LIM = PRB_W'(MAX_PRB);
  localparam logic [PRB_W-1:0] GUARD   = PRB_W'(EDGE_GUARD);

  state_t           state, state_next;
  logic [MAP_W-1:0] bitmap, bitmap_next;
  logic [PRB_W-1:0] idx, idx_next;
  logic [PRB_W-1:0] run_start, run_start_next;
  logic [PRB_W-1:0] run_len, run_len_next;
  logic [PRB_W-1:0] req, req_next;
  logic [PRB_W-1:0] cell_prbs;
  logic [PRB_W-1:0] limit;
  result_t          result_next;
  logic             done_next;

  assign limit     = (cell_prbs < MAX_LIM) ? cell_prbs : MAX_LIM;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    bitmap_next    = bitmap;
    idx_next       = idx;
    run_start_next = run_start;
    run_len_next   = run_len;
    req_next       = req;
    result_next    = result;
    done_next      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          bitmap_next    = {item.used_high, item.used_low};
          req_next       = item.requested_len;
          idx_next       = '0;
          run_start_next = '0;
          run_len_next   = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((idx >= limit) || (run_len >= req)) begin
          state_next = ST_REDUCE;
        end else begin
          bitmap_next = bitmap >> 1;
          idx_next    = idx + PRB_W'(1);
          if (!bitmap[0]) begin
            if (run_len == '0) begin
              run_start_next = idx;
            end
            run_len_next = run_len + PRB_W'(1);
          end else if (run_len != '0) begin
            // A run cut short at the lower band edge is discarded.
            if (idx < GUARD) begin
              run_start_next = '0;
              run_len_next   = '0;
            end else begin
              state_next = ST_REDUCE;
            end
          end
        end
      end
      ST_REDUCE: begin
        if (run_len == '0) begin
          result_next = '0;
          done_next   = 1'b1;
          state_next  = ST_IDLE;
        end else if (len_allowed(run_len)) begin
          result_next.run_start = run_start;
          result_next.run_len   = run_len;
          result_next.exact_fit = (run_len == req);
          done_next             = 1'b1;
          state_next            = ST_IDLE;
        end else begin
          run_len_next = run_len - PRB_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      cell_prbs <= PRB_W'(CELL_RESET);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        cell_prbs <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bitmap    <= bitmap_next;
    idx       <= idx_next;
    run_start <= run_start_next;
    run_len   <= run_len_next;
    req       <= req_next;
    result    <= result_next;
  end

endmodule

`default_nettype wire

FILE: rtl/cprf_checker.sv
// ----------------------------------------------------------------------------
// cprf_checker
// Port-level checks of the PRB run finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cprf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire cprf_pkg::result_t result
);
  import cprf_pkg::*;

  // An accepted search makes the block busy, with done still low.
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done)
  // The done transaction frees the block in the same cycle.
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  // An empty run reports zero start and no exact fit.
  `ASSERT_IMPL(a_empty_run, clk, rst, done && (result.run_len == '0),
    (result.run_start == '0) && !result.exact_fit)
  // The granted run never leaves the band.
  `ASSERT_IMPL(a_in_band, clk, rst, done,
    (result.run_len <= 7'd100) && (result.run_start <= 7'd99))

endmodule

bind contiguous_prb_run_finder cprf_checker u_cprf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

FILE: tb/tb_contiguous_prb_run_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_prb_run_finder
// Self-checking bench for the contiguous PRB run finder. A directed table
// covers the bitmap extremes, the low-edge guard, the length trimming and
// odd cell sizes. Random bitmaps follow under a series of cell sizes. Every
// result is checked against a typed-in expectation or an in-bench model of the search.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_contiguous_prb_run_finder;
  import cprf_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct {
    logic [PRB_W-1:0]  cell_size;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
    logic [PRB_W-1:0]  req;
    bit                typed;
    result_t           grant;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PRB_W-1:0] cfg_data = '0;

  // Travels with the item so that a typed-in expectation replaces the model.
  bit row_typed = 1'b0;
  result_t row_grant = '0;

  logic [PRB_W-1:0] model_cell = PRB_W'(CELL_RESET);
  logic [PRB_W-1:0] cur_cell = PRB_W'(CELL_RESET);
  result_t grant_q[$];
  result_t want;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  stim_row_t directed_rows[24];

  contiguous_prb_run_finder uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit smooth_len(int unsigned v);
    if (v == 0) return 1'b0;
    while (v % 2 == 0) v = v / 2;
    while (v % 3 == 0) v = v / 3;
    while (v % 5 == 0) v = v / 5;
    return v == 1;
  endfunction

  function automatic result_t grant_for(item_t it, logic [PRB_W-1:0] cell_size);
    logic [MAP_W-1:0] taken;
    int unsigned span;
    int unsigned first;
    int unsigned run;
    result_t g;
    taken = {it.used_high, it.used_low};
    span = (cell_size < MAX_PRB_DF) ? cell_size : MAX_PRB_DF;
    first = 0;
    run = 0;
    g = '0;
    for (int n = 0; n < span && run < it.requested_len; n++) begin
      if (!taken[n]) begin
        if (run == 0) first = n;
        run++;
      end else if (run > 0) begin
        // A run broken near the band edge is thrown away; higher up it ends the scan.
        if (n < EDGE_GUARD) begin
          first = 0;
          run = 0;
        end else begin
          break;
        end
      end
    end
    if (run != 0) begin
      while (!smooth_len(run)) run--;
      g.run_start = PRB_W'(first);
      g.run_len = PRB_W'(run);
      g.exact_fit = (run == it.requested_len);
    end
    return g;
  endfunction

  // Bitmaps come in a few shapes: empty, uniform density, one free window,
  // and traffic aimed at the first few PRBs where runs get dropped.
  function automatic item_t random_item();
    logic [MAP_W-1:0] taken;
    int unsigned mode;
    int unsigned dense;
    int unsigned win_lo;
    int unsigned win_w;
    int unsigned pick;
    item_t it;
    mode = $urandom_range(0, 9);
    taken = '0;
    if (mode >= 1 && mode <= 4) begin
      dense = $urandom_range(0, 16);
      for (int b = 0; b < MAP_W; b++) taken[b] = ($urandom_range(0, 15) < dense);
    end else if (mode >= 5 && mode <= 7) begin
      taken = '1;
      win_lo = $urandom_range(0, MAP_W - 1);
      win_w = $urandom_range(0, MAP_W);
      for (int b = 0; b < MAP_W; b++) begin
        if (b >= win_lo && b < win_lo + win_w) taken[b] = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) taken[$urandom_range(0, MAP_W - 1)] = 1'b1;
    end else if (mode >= 8) begin
      for (int b = 0; b < MAP_W; b++) begin
        taken[b] = (b < 4) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0);
      end
    end
    it.used_low = taken[LOW_W-1:0];
    it.used_high = taken[MAP_W-1:LOW_W];
    pick = $urandom_range(0, 9);
    if (pick < 6) it.requested_len = PRB_W'($urandom_range(1, 100));
    else if (pick < 8) it.requested_len = PRB_W'($urandom_range(0, 8));
    else it.requested_len = PRB_W'($urandom_range(64, 127));
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t g);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    row_typed <= typed;
    row_grant <= g;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_cell(logic [PRB_W-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_cell = v;
  endtask

  // Scoreboard: results are retired before new transactions are queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result start %0d len %0d fit %0d", $time,
                   result.run_start, result.run_len, result.exact_fit);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          if (result.run_start !== want.run_start) begin
            $display("%0t: run_start expected %0d actual %0d", $time,
                     want.run_start, result.run_start);
            mismatches++;
          end
          if (result.run_len !== want.run_len) begin
            $display("%0t: run_len expected %0d actual %0d", $time,
                     want.run_len, result.run_len);
            mismatches++;
          end
          if (result.exact_fit !== want.exact_fit) begin
            $display("%0t: exact_fit expected %0d actual %0d", $time,
                     want.exact_fit, result.exact_fit);
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        grant_q.push_back(row_typed ? row_grant : grant_for(item, model_cell));
      end
      if (cfg_valid && cfg_ready === 1'b1) model_cell = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [PRB_W-1:0] phase_cell[13];
    item_t it;
    directed_rows = '{
      '{7'd100, 64'h0, 36'h0, 7'd100, 1'b1, {7'd0, 7'd100, 1'b1}},
      '{7'd100, '1, '1, 7'd100, 1'b1, {7'd0, 7'd0, 1'b0}},
      '{7'd100, 64'h0, 36'h0, 7'd0, 1'b1, {7'd0, 7'd0, 1'b0}},
      '{7'd100, 64'h0, 36'h0, 7'd7, 1'b1, {7'd0, 7'd6, 1'b0}},
      '{7'd100, 64'h1, 36'h0, 7'd5, 1'b1, {7'd1, 7'd5, 1'b1}},
      '{7'd100, 64'h2, 36'h0, 7'd10, 1'b1, {7'd2, 7'd10, 1'b1}},
      '{7'd100, 64'h4, 36'h0, 7'd10, 1'b1, {7'd3, 7'd10, 1'b1}},
      '{7'd100, 64'h8, 36'h0, 7'd10, 1'b1, {7'd0, 7'd3, 1'b0}},
      '{7'd100, 64'h0, 36'h0, 7'd99, 1'b1, {7'd0, 7'd96, 1'b0}},
      '{7'd100, '1, 36'h0, 7'd36, 1'b1, {7'd64, 7'd36, 1'b1}},
      '{7'd100, '1, 36'h7_FFFF_FFFF, 7'd1, 1'b1, {7'd99, 7'd1, 1'b1}},
      '{7'd100, 64'h7FFF_FFFF_FFFF_FFFF, 36'h1, 7'd50, 1'b1, {7'd63, 7'd1, 1'b0}},
      '{7'd100, 64'hA5A5_A5A5_A5A5_A5A5, 36'h5_5555_5555, 7'd3, 1'b0, '0},
      '{7'd100, 64'hFFFF_0000_F0F0_0F0F, 36'hF_0000_FFFF, 7'd40, 1'b0, '0},
      '{7'd100, 64'h0000_0000_0000_00F0, 36'h0, 7'd127, 1'b0, '0},
      '{7'd64, 64'h0, '1, 7'd100, 1'b1, {7'd0, 7'd64, 1'b0}},
      '{7'd64, '1, 36'h0, 7'd5, 1'b1, {7'd0, 7'd0, 1'b0}},
      '{7'd6, 64'h0, 36'h0, 7'd100, 1'b1, {7'd0, 7'd6, 1'b0}},
      '{7'd6, 64'h1, 36'h0, 7'd5, 1'b1, {7'd1, 7'd5, 1'b1}},
      '{7'd5, 64'h0, 36'h0, 7'd5, 1'b1, {7'd0, 7'd5, 1'b1}},
      '{7'd1, 64'h0, 36'h0, 7'd5, 1'b1, {7'd0, 7'd1, 1'b0}},
      '{7'd0, 64'h0, 36'h0, 7'd5, 1'b1, {7'd0, 7'd0, 1'b0}},
      '{7'd127, 64'h0, 36'h0, 7'd127, 1'b1, {7'd0, 7'd100, 1'b0}},
      '{7'd127, 64'h0, 36'h0, 7'd100, 1'b1, {7'd0, 7'd100, 1'b1}}
    };
    phase_cell = '{7'd100, 7'd127, 7'd0, 7'd1, 7'd5, 7'd6, 7'd64, 7'd65, 7'd99,
                   7'd0, 7'd0, 7'd0, 7'd100};
    for (int p = 9; p < 12; p++) phase_cell[p] = PRB_W'($urandom_range(6, 100));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].cell_size != cur_cell) set_cell(directed_rows[r].cell_size);
      it.used_low = directed_rows[r].lo;
      it.used_high = directed_rows[r].hi;
      it.requested_len = directed_rows[r].req;
      send_item(it, directed_rows[r].typed, directed_rows[r].grant);
    end

    // Degenerate cell sizes get short phases; the rest carry the bulk.
    foreach (phase_cell[p]) begin
      set_cell(phase_cell[p]);
      repeat ((phase_cell[p] < 6) ? 40 : 180) send_item(random_item(), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
